// ----- design/assert_macros.svh -----
// Assertion macros shared by the group layout hash RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define GLF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define GLF_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GLF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GLF_ASSERT(lbl, clk, rstn, prop)
`define GLF_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define GLF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- design/glfnv_pkg.sv -----
// Types, constants and the FNV-1a round for the group layout hash block.
// No dependencies; used by the controller, datapath and top level.
package glfnv_pkg;

    localparam int ENTRY_BYTES = 12;
    localparam int CNT_W       = $clog2(ENTRY_BYTES);
    localparam int BYTES_W     = ENTRY_BYTES * 8;
    localparam int HASH_W      = 64;
    localparam int PRIME_SHIFT = 40;

    typedef logic [HASH_W-1:0] t_hash;
    typedef logic [7:0]        t_byte;

    localparam t_hash      FNV_BASIS    = 64'hcbf29ce484222325;
    localparam logic [8:0] FNV_PRIME_LO = 9'h1b3;
    localparam t_hash      HASH_ONE     = 64'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_CLOSE,
        S_SEED,
        S_MIX,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic seed;
        logic mix;
        logic emit_close;
        logic emit_final;
    } t_cmd;

    typedef struct packed {
        logic group_change;
        logic active;
        logic out_free;
        logic last;
    } t_stat;

    // prime = 2^40 + 0x1b3, so the product is a shift plus a narrow multiply
    function automatic t_hash fnv_round(input t_hash h, input t_byte b);
        t_hash x;
        x = h ^ {{(HASH_W-8){1'b0}}, b};
        return (x << PRIME_SHIFT) + (x * FNV_PRIME_LO);
    endfunction

endpackage

// ----- design/group_layout_fnv_hash_top.sv -----
// Group layout hash: one binding entry per item, FNV-1a 64 id per closed group.
// One item at a time; the input stalls until it is done: accept, group check and
// 12 entry-byte rounds, plus group-byte seed, close and final emit steps as needed.
// A result is registered at the close step (group change) or the emit step (last entry),
// and the close or emit waits while the output is stalled.
// Reset: synchronous active low; clears the sequencer, open group and output valid.
module group_layout_fnv_hash_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_group,
    input  logic [7:0]  i_binding,
    input  logic [7:0]  i_kind,
    input  logic [7:0]  i_stage_mask,
    input  logic [15:0] i_slot_vertex,
    input  logic [15:0] i_slot_fragment,
    input  logic [15:0] i_slot_compute,
    input  logic [7:0]  i_view_dim,
    input  logic [7:0]  i_sample_type,
    input  logic        i_multisampled,
    input  logic        i_last_entry,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_group,
    output logic [63:0] o_layout_id,
    output logic        o_last_result
);

    glfnv_pkg::t_cmd  cmd;
    glfnv_pkg::t_stat stat;

    glfnv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    glfnv_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_group         (i_group),
        .i_binding       (i_binding),
        .i_kind          (i_kind),
        .i_stage_mask    (i_stage_mask),
        .i_slot_vertex   (i_slot_vertex),
        .i_slot_fragment (i_slot_fragment),
        .i_slot_compute  (i_slot_compute),
        .i_view_dim      (i_view_dim),
        .i_sample_type   (i_sample_type),
        .i_multisampled  (i_multisampled),
        .i_last_entry    (i_last_entry),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_out_group     (o_out_group),
        .o_layout_id     (o_layout_id),
        .o_last_result   (o_last_result)
    );

endmodule

// ----- design/glfnv_ctrl.sv -----
// Sequencer for the group layout hash: close, seed, byte rounds, emit.
// Depends on glfnv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module glfnv_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  glfnv_pkg::t_stat  i_stat,
    output glfnv_pkg::t_cmd   o_cmd
);

    glfnv_pkg::t_state                r_state, n_state;
    logic [glfnv_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic                             mix_done;

    assign mix_done = (r_cnt == glfnv_pkg::CNT_W'(glfnv_pkg::ENTRY_BYTES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= glfnv_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            glfnv_pkg::S_IDLE: begin
                if (i_valid) n_state = glfnv_pkg::S_CHECK;
            end
            glfnv_pkg::S_CHECK: begin
                if (i_stat.group_change)  n_state = glfnv_pkg::S_CLOSE;
                else if (!i_stat.active)  n_state = glfnv_pkg::S_SEED;
                else                      n_state = glfnv_pkg::S_MIX;
            end
            glfnv_pkg::S_CLOSE: begin
                if (i_stat.out_free) n_state = glfnv_pkg::S_SEED;
            end
            glfnv_pkg::S_SEED: begin
                n_state = glfnv_pkg::S_MIX;
            end
            glfnv_pkg::S_MIX: begin
                if (mix_done) n_state = i_stat.last ? glfnv_pkg::S_EMIT : glfnv_pkg::S_IDLE;
            end
            glfnv_pkg::S_EMIT: begin
                if (i_stat.out_free) n_state = glfnv_pkg::S_IDLE;
            end
            default: n_state = glfnv_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        n_cnt   = '0;
        case (r_state)
            glfnv_pkg::S_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            glfnv_pkg::S_CHECK: begin
            end
            glfnv_pkg::S_CLOSE: begin
                o_cmd.emit_close = i_stat.out_free;
            end
            glfnv_pkg::S_SEED: begin
                o_cmd.seed = 1'b1;
            end
            glfnv_pkg::S_MIX: begin
                o_cmd.mix = 1'b1;
                n_cnt     = mix_done ? '0 : r_cnt + 1'b1;
            end
            glfnv_pkg::S_EMIT: begin
                o_cmd.emit_final = i_stat.out_free;
            end
            default: begin
            end
        endcase
    end

    `GLF_ASSERT_NEXT(a_seed_then_mix, i_clk, i_rst_n, r_state == glfnv_pkg::S_SEED,
        r_state == glfnv_pkg::S_MIX && r_cnt == '0)
    `GLF_ASSERT_IMPL(a_cnt_only_in_mix, i_clk, i_rst_n, r_cnt != '0,
        r_state == glfnv_pkg::S_MIX)
    `GLF_ASSERT_NEXT(a_last_goes_emit, i_clk, i_rst_n,
        r_state == glfnv_pkg::S_MIX && mix_done && i_stat.last,
        r_state == glfnv_pkg::S_EMIT)

endmodule

// ----- design/glfnv_dp.sv -----
// Datapath: item byte register, running FNV-1a hash, open group and output register.
// Depends on glfnv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module glfnv_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  glfnv_pkg::t_cmd   i_cmd,
    output glfnv_pkg::t_stat  o_stat,
    input  logic [7:0]        i_group,
    input  logic [7:0]        i_binding,
    input  logic [7:0]        i_kind,
    input  logic [7:0]        i_stage_mask,
    input  logic [15:0]       i_slot_vertex,
    input  logic [15:0]       i_slot_fragment,
    input  logic [15:0]       i_slot_compute,
    input  logic [7:0]        i_view_dim,
    input  logic [7:0]        i_sample_type,
    input  logic              i_multisampled,
    input  logic              i_last_entry,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [7:0]        o_out_group,
    output logic [63:0]       o_layout_id,
    output logic              o_last_result
);

    logic [glfnv_pkg::BYTES_W-1:0] r_bytes;
    logic [7:0]                    r_in_group;
    logic                          r_last;
    glfnv_pkg::t_hash              r_hash;
    logic [7:0]                    r_open_group;
    logic                          r_active;
    logic                          r_out_valid;
    logic [7:0]                    r_out_group;
    glfnv_pkg::t_hash              r_layout_id;
    logic                          r_last_result;
    logic                          emit;
    glfnv_pkg::t_hash              fixed_hash;

    assign emit       = i_cmd.emit_close | i_cmd.emit_final;
    assign fixed_hash = (r_hash == '0) ? glfnv_pkg::HASH_ONE : r_hash;

    assign o_stat.group_change = r_active && (r_in_group != r_open_group);
    assign o_stat.active       = r_active;
    assign o_stat.out_free     = !r_out_valid || !i_stall;
    assign o_stat.last         = r_last;

    // bytes leave from the low end, slots low byte first
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bytes    <= {7'b0, i_multisampled, i_sample_type, i_view_dim,
                           i_slot_compute, i_slot_fragment, i_slot_vertex,
                           i_stage_mask, i_kind, i_binding};
            r_in_group <= i_group;
            r_last     <= i_last_entry;
        end else if (i_cmd.mix) begin
            r_bytes <= r_bytes >> 8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash       <= '0;
            r_open_group <= '0;
            r_active     <= 1'b0;
        end else if (i_cmd.seed) begin
            r_hash       <= glfnv_pkg::fnv_round(glfnv_pkg::FNV_BASIS, r_in_group);
            r_open_group <= r_in_group;
            r_active     <= 1'b1;
        end else if (i_cmd.mix) begin
            r_hash <= glfnv_pkg::fnv_round(r_hash, r_bytes[7:0]);
        end else if (emit) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_group   <= r_open_group;
            r_layout_id   <= fixed_hash;
            r_last_result <= i_cmd.emit_final | !r_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_group   = r_out_group;
    assign o_layout_id   = r_layout_id;
    assign o_last_result = r_last_result;

    `GLF_ASSERT_IMPL(a_emit_needs_room, i_clk, i_rst_n, emit, o_stat.out_free)
    `GLF_ASSERT_IMPL(a_mix_needs_group, i_clk, i_rst_n, i_cmd.mix, r_active)
    `GLF_ASSERT(a_id_nonzero, i_clk, i_rst_n, !r_out_valid || r_layout_id != '0)

endmodule

// ----- test/group_layout_fnv_hash_checker.sv -----
// Checker for the group layout hash block: watches both channels, predicts the
// per-group FNV-1a 64 layout ids and compares every accepted result in order.
// Depends on glfnv_pkg for the hash type and offset basis.
module group_layout_fnv_hash_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_group,
    input  logic [7:0]  i_binding,
    input  logic [7:0]  i_kind,
    input  logic [7:0]  i_stage_mask,
    input  logic [15:0] i_slot_vertex,
    input  logic [15:0] i_slot_fragment,
    input  logic [15:0] i_slot_compute,
    input  logic [7:0]  i_view_dim,
    input  logic [7:0]  i_sample_type,
    input  logic        i_multisampled,
    input  logic        i_last_entry,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_out_group,
    input  logic [63:0] i_layout_id,
    input  logic        i_last_result,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam glfnv_pkg::t_hash FNV_PRIME_64 = 64'h0000_0100_0000_01b3;
    localparam int               MAX_REPORTS  = 10;

    typedef struct packed {
        logic [7:0]       grp;
        glfnv_pkg::t_hash id;
        logic             last;
    } t_layout_report;

    t_layout_report   layout_ids_due[$];
    glfnv_pkg::t_hash group_hash;
    logic [7:0]       cur_group;
    logic             group_open;
    int               fail_count;

    initial begin
        fail_count = 0;
        group_hash = '0;
        cur_group  = '0;
        group_open = 1'b0;
    end

    function automatic glfnv_pkg::t_hash fnv_mix(input glfnv_pkg::t_hash h,
                                                 input logic [7:0] b);
        return (h ^ {56'd0, b}) * FNV_PRIME_64;
    endfunction

    function automatic glfnv_pkg::t_hash fnv_mix_half(input glfnv_pkg::t_hash h,
                                                      input logic [15:0] v);
        return fnv_mix(fnv_mix(h, v[7:0]), v[15:8]);
    endfunction

    function automatic t_layout_report close_group(input logic [7:0] g,
                                                   input glfnv_pkg::t_hash h);
        t_layout_report r;
        r.grp  = g;
        r.id   = (h == '0) ? 64'd1 : h;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic predict_layout_ids();
        t_layout_report   r0;
        t_layout_report   r1;
        int               n;
        glfnv_pkg::t_hash h;
        n = 0;
        if (group_open && i_group != cur_group) begin
            r0 = close_group(cur_group, group_hash);
            n = 1;
            group_open = 1'b0;
        end
        if (!group_open) begin
            group_hash = fnv_mix(glfnv_pkg::FNV_BASIS, i_group);
            cur_group  = i_group;
            group_open = 1'b1;
        end
        h = group_hash;
        h = fnv_mix(h, i_binding);
        h = fnv_mix(h, i_kind);
        h = fnv_mix(h, i_stage_mask);
        h = fnv_mix_half(h, i_slot_vertex);
        h = fnv_mix_half(h, i_slot_fragment);
        h = fnv_mix_half(h, i_slot_compute);
        h = fnv_mix(h, i_view_dim);
        h = fnv_mix(h, i_sample_type);
        h = fnv_mix(h, {7'd0, i_multisampled});
        group_hash = h;
        if (i_last_entry) begin
            if (n == 0) r0 = close_group(cur_group, group_hash);
            else        r1 = close_group(cur_group, group_hash);
            n++;
            group_open = 1'b0;
        end
        if (n == 1) begin
            r0.last = 1'b1;
            layout_ids_due.insert(layout_ids_due.size(), r0);
        end else if (n == 2) begin
            r1.last = 1'b1;
            layout_ids_due.insert(layout_ids_due.size(), r0);
            layout_ids_due.insert(layout_ids_due.size(), r1);
        end
    endtask

    task automatic check_layout_id();
        t_layout_report want;
        if (layout_ids_due.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("unexpected result: group %0d id %h last %0b",
                         i_out_group, i_layout_id, i_last_result);
        end else begin
            want = layout_ids_due.pop_front();
            if (want.grp != i_out_group || want.id != i_layout_id ||
                want.last != i_last_result) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("mismatch: exp group %0d id %h last %0b, got %0d %h %0b",
                             want.grp, want.id, want.last,
                             i_out_group, i_layout_id, i_last_result);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            layout_ids_due.delete();
            group_hash = '0;
            cur_group  = '0;
            group_open = 1'b0;
        end else begin
            if (i_out_valid && !i_out_stall) check_layout_id();
            if (i_in_valid && !i_in_stall) predict_layout_ids();
        end
        o_pending    = layout_ids_due.size();
        o_fail_count = fail_count;
    end

endmodule

// ----- test/tb_group_layout_fnv_hash_top.sv -----
// Testbench top for group_layout_fnv_hash_top: drives directed and random
// binding entries with idle and stall bursts and gives the verdict.
// Depends on the block, glfnv_pkg and group_layout_fnv_hash_checker.
module tb_group_layout_fnv_hash_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1700;
    localparam int QUIET_ITEMS  = 150;
    localparam int HOLD_AT_ITEM = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic [7:0]  grp;
        logic [7:0]  binding;
        logic [7:0]  kind;
        logic [7:0]  stage_mask;
        logic [15:0] slot_v;
        logic [15:0] slot_f;
        logic [15:0] slot_c;
        logic [7:0]  view_dim;
        logic [7:0]  sample_type;
        logic        ms;
        logic        last;
    } t_bind_entry;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_group;
    logic [7:0]  i_binding;
    logic [7:0]  i_kind;
    logic [7:0]  i_stage_mask;
    logic [15:0] i_slot_vertex;
    logic [15:0] i_slot_fragment;
    logic [15:0] i_slot_compute;
    logic [7:0]  i_view_dim;
    logic [7:0]  i_sample_type;
    logic        i_multisampled;
    logic        i_last_entry;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_out_group;
    logic [63:0] o_layout_id;
    logic        o_last_result;

    int fail_count;
    int pending_ids;
    int cycle_count = 0;
    bit quiet = 1'b0;
    bit long_hold_req = 1'b0;

    always #10 i_clk = ~i_clk;

    group_layout_fnv_hash_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_group         (i_group),
        .i_binding       (i_binding),
        .i_kind          (i_kind),
        .i_stage_mask    (i_stage_mask),
        .i_slot_vertex   (i_slot_vertex),
        .i_slot_fragment (i_slot_fragment),
        .i_slot_compute  (i_slot_compute),
        .i_view_dim      (i_view_dim),
        .i_sample_type   (i_sample_type),
        .i_multisampled  (i_multisampled),
        .i_last_entry    (i_last_entry),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_group     (o_out_group),
        .o_layout_id     (o_layout_id),
        .o_last_result   (o_last_result)
    );

    group_layout_fnv_hash_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_group         (i_group),
        .i_binding       (i_binding),
        .i_kind          (i_kind),
        .i_stage_mask    (i_stage_mask),
        .i_slot_vertex   (i_slot_vertex),
        .i_slot_fragment (i_slot_fragment),
        .i_slot_compute  (i_slot_compute),
        .i_view_dim      (i_view_dim),
        .i_sample_type   (i_sample_type),
        .i_multisampled  (i_multisampled),
        .i_last_entry    (i_last_entry),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_out_group     (o_out_group),
        .i_layout_id     (o_layout_id),
        .i_last_result   (o_last_result),
        .o_fail_count    (fail_count),
        .o_pending       (pending_ids)
    );

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_half();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_bind_entry random_entry(input logic [7:0] g, input logic last);
        t_bind_entry e;
        e.grp         = g;
        e.binding     = rand_byte();
        e.kind        = rand_byte();
        e.stage_mask  = rand_byte();
        e.slot_v      = rand_half();
        e.slot_f      = rand_half();
        e.slot_c      = rand_half();
        e.view_dim    = rand_byte();
        e.sample_type = rand_byte();
        e.ms          = 1'($urandom);
        e.last        = last;
        return e;
    endfunction

    function automatic t_bind_entry filled_entry(input logic [7:0] g, input logic [7:0] fill,
                                                 input logic last);
        t_bind_entry e;
        e.grp         = g;
        e.binding     = fill;
        e.kind        = fill;
        e.stage_mask  = fill;
        e.slot_v      = {fill, fill};
        e.slot_f      = {fill, fill};
        e.slot_c      = {fill, fill};
        e.view_dim    = fill;
        e.sample_type = fill;
        e.ms          = fill[0];
        e.last        = last;
        return e;
    endfunction

    task automatic send_entry(input t_bind_entry e, input bit may_idle);
        int gap;
        gap = 0;
        if (may_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
        @(negedge i_clk);
        repeat (gap) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_group         <= e.grp;
        i_binding       <= e.binding;
        i_kind          <= e.kind;
        i_stage_mask    <= e.stage_mask;
        i_slot_vertex   <= e.slot_v;
        i_slot_fragment <= e.slot_f;
        i_slot_compute  <= e.slot_c;
        i_view_dim      <= e.view_dim;
        i_sample_type   <= e.sample_type;
        i_multisampled  <= e.ms;
        i_last_entry    <= e.last;
        i_valid         <= 1'b1;
        do @(posedge i_clk); while (o_stall);
    endtask

    // receiver: short stall bursts, calm stretches, one long hold-off
    initial begin
        int  stall_left;
        int  calm_left;
        bit  calm;
        bit  hold_done;
        stall_left = 0;
        calm_left  = 0;
        calm       = 1'b0;
        hold_done  = 1'b0;
        i_stall    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (calm_left == 0) begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = 128;
            end
            calm_left--;
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (long_hold_req && !hold_done) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                i_stall <= 1'b1;
            end else if (quiet || calm || !i_rst_n) begin
                i_stall <= 1'b0;
            end else if ($urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 2);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb_group_layout_fnv_hash_top failed");
            $finish;
        end
    end

    initial begin
        t_bind_entry e;
        logic [7:0]  run_group;
        int          pick;
        int          idx;
        bit          may_idle;

        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_group         = '0;
        i_binding       = '0;
        i_kind          = '0;
        i_stage_mask    = '0;
        i_slot_vertex   = '0;
        i_slot_fragment = '0;
        i_slot_compute  = '0;
        i_view_dim      = '0;
        i_sample_type   = '0;
        i_multisampled  = 1'b0;
        i_last_entry    = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, group change, last entry, both at once, reappearing group
        send_entry(filled_entry(8'd0, 8'h00, 1'b0), 1'b1);
        send_entry(filled_entry(8'd0, 8'hff, 1'b0), 1'b1);
        send_entry(random_entry(8'd0, 1'b1), 1'b1);
        send_entry(filled_entry(8'd0, 8'h00, 1'b1), 1'b1);
        send_entry(filled_entry(8'd255, 8'hff, 1'b0), 1'b1);
        send_entry(random_entry(8'd255, 1'b0), 1'b1);
        send_entry(random_entry(8'd1, 1'b0), 1'b1);
        send_entry(random_entry(8'd2, 1'b1), 1'b1);
        send_entry(random_entry(8'd2, 1'b0), 1'b1);
        send_entry(random_entry(8'd2, 1'b1), 1'b1);
        send_entry(random_entry(8'd7, 1'b1), 1'b1);
        send_entry(random_entry(8'd7, 1'b0), 1'b1);
        send_entry(random_entry(8'd3, 1'b0), 1'b1);
        send_entry(random_entry(8'd7, 1'b0), 1'b1);
        send_entry(filled_entry(8'd7, 8'hff, 1'b1), 1'b1);
        e = filled_entry(8'd128, 8'h00, 1'b0);
        e.slot_v = 16'h00ff;
        e.slot_f = 16'hff00;
        e.slot_c = 16'h5aa5;
        send_entry(e, 1'b1);
        e = filled_entry(8'd129, 8'hff, 1'b1);
        e.slot_v = 16'hff00;
        e.slot_f = 16'h00ff;
        e.ms     = 1'b0;
        send_entry(e, 1'b1);
        e = filled_entry(8'd0, 8'h00, 1'b1);
        e.ms = 1'b1;
        send_entry(e, 1'b1);
        send_entry(filled_entry(8'd170, 8'h55, 1'b0), 1'b1);
        send_entry(filled_entry(8'd85, 8'haa, 1'b1), 1'b1);

        run_group = 8'($urandom);
        for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)      run_group = run_group;
            else if (pick < 88) run_group = run_group + 8'($urandom_range(1, 4));
            else                run_group = 8'($urandom);
            e = random_entry(run_group, ($urandom_range(0, 7) == 0) || idx == RANDOM_ITEMS - 1);
            if (idx == HOLD_AT_ITEM) long_hold_req = 1'b1;
            if (idx == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            may_idle = !quiet && ((idx / 40) % 4 != 0);
            send_entry(e, may_idle);
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (pending_ids != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_group_layout_fnv_hash_top passed");
        else
            $display("tb_group_layout_fnv_hash_top failed");
        $finish;
    end

endmodule
